[hw/rtl/emld_pkg.sv]
// emld_pkg: shared widths, register indexes and helpers for the epipolar distance block
// no dependencies; used by emld_mul and epipolar_max_line_distance
package emld_pkg;

  // field and chunk widths
  localparam int CHUNK_W = 32;
  localparam int COEF_W  = 21;
  localparam int PT_W    = 32;
  localparam int ERR_W   = 32;
  localparam int ROW_W   = 3 * COEF_W;
  localparam int IN_W    = 4 * PT_W;
  localparam int CFG_A_W = 2;

  // internal arithmetic widths
  localparam int PA_W = COEF_W + PT_W;    // coefficient times point
  localparam int L_W  = 55;               // line coefficient, Q.34
  localparam int PD_W = L_W + PT_W;       // line coefficient times point
  localparam int PN_W = 2 * L_W;          // line coefficient squared
  localparam int D_W  = 88;               // point to line value, Q.50
  localparam int N_W  = PN_W + 1;         // squared normal length, Q.68
  localparam int D2_W = 2 * D_W;          // squared point to line value, Q.100
  localparam int M_W  = N_W + 16;         // divisor

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_ROW2 = 2'd2;

  // flags of one side travelling alongside the divider
  typedef struct packed {
    logic deg;
    logic sat;
  } side_flags_t;

  // partial products needed for a wa by wb magnitude product
  function automatic int mul_stages(input int wa, input int wb);
    return ((wa + CHUNK_W - 1) / CHUNK_W) * ((wb + CHUNK_W - 1) / CHUNK_W);
  endfunction

  // signed coefficient k of a packed matrix row
  function automatic logic signed [COEF_W-1:0] coef(input logic [ROW_W-1:0] row,
                                                    input int k);
    return $signed(row[COEF_W*k +: COEF_W]);
  endfunction

endpackage

[hw/rtl/emld_mul.sv]
// emld_mul: pipelined signed multiplier, one 32x32 partial product per stage
// depends on emld_pkg; registers the input magnitudes, every stage and the signed product
module emld_mul #(
  parameter int WA     = 32,
  parameter int WB     = 32,
  parameter int STAGES = 1
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int CW = emld_pkg::CHUNK_W;
  localparam int NA = (WA + CW - 1) / CW;
  localparam int NB = (WB + CW - 1) / CW;
  localparam int PW = WA + WB;
  localparam int AW = NA * CW;
  localparam int BW = NB * CW;

  logic [WA-1:0]        abs_a;
  logic [WB-1:0]        abs_b;
  logic [AW-1:0]        ma_r  [0:STAGES-1];
  logic [BW-1:0]        mb_r  [0:STAGES-1];
  logic                 sg_r  [0:STAGES];
  logic [PW-1:0]        acc_r [0:STAGES];
  logic signed [PW-1:0] p_r;

  // sign and magnitude split
  assign abs_a = a[WA-1] ? (~a + 1'b1) : a;
  assign abs_b = b[WB-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r[0]  <= AW'(abs_a);
      mb_r[0]  <= BW'(abs_b);
      sg_r[0]  <= a[WA-1] ^ b[WB-1];
      acc_r[0] <= '0;
    end
  end

  // one partial product accumulated per stage
  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    localparam int K  = s - 1;
    localparam int I  = K % NA;
    localparam int J  = K / NA;
    localparam int SH = (I + J) * CW;
    logic [PW-1:0] acc_nxt;

    if (K < NA * NB) begin : g_pp
      logic [2*CW-1:0] pp;
      assign pp      = ma_r[s-1][I*CW +: CW] * mb_r[s-1][J*CW +: CW];
      assign acc_nxt = acc_r[s-1] + PW'({{PW{1'b0}}, pp} << SH);
    end else begin : g_pass
      assign acc_nxt = acc_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sg_r[s]  <= sg_r[s-1];
        acc_r[s] <= acc_nxt;
      end
    end

    if (s < STAGES) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          ma_r[s] <= ma_r[s-1];
          mb_r[s] <= mb_r[s-1];
        end
      end
    end
  end

  // restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= $signed(sg_r[STAGES] ? (~acc_r[STAGES] + 1'b1) : acc_r[STAGES]);
    end
  end

  assign p = p_r;

endmodule

[hw/rtl/emld_dly.sv]
// emld_dly: enable-gated delay line that keeps side data aligned with the multipliers
// depends on nothing but the clock
module emld_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [0:N-1];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign q = sh_r[N-1];

endmodule

[hw/rtl/emld_div.sv]
// emld_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing but the clock
module emld_div #(
  parameter int RW = 64,
  parameter int MW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_in,
  input  logic [MW-1:0] m_in,
  output logic [QW-1:0] q
);

  logic [RW-1:0] rem_r [0:QW-1];
  logic [MW-1:0] m_r   [0:QW-2];
  logic [QW-1:0] q_r   [0:QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [RW-1:0] rem_p;
    logic [MW-1:0] m_p;
    logic [QW-1:0] q_p;
    logic [RW-1:0] t;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = rem_in;
      assign m_p   = m_in;
      assign q_p   = '0;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign m_p   = m_r[k-1];
      assign q_p   = q_r[k-1];
    end

    // trial subtract of the shifted divisor
    assign t  = RW'(m_p) << B;
    assign ge = (rem_p >= t);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_p - t) : rem_p;
        q_r[k]   <= q_p | (QW'(ge) << B);
      end
    end

    if (k < QW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          m_r[k] <= m_p;
        end
      end
    end
  end

  assign q = q_r[QW-1];

endmodule

[hw/rtl/epipolar_max_line_distance.sv]
// Symmetric epipolar distance for one point correspondence per transaction.
// Input stream: in_tdata = {y2, x2, y1, x1}, signed Q16.16 each, x1 in the low bits.
// Output stream: out_tdata = error (unsigned Q16.16, saturating), out_tuser = degenerate.
// Config channel: cfg_addr selects matrix row 0..2, cfg_data holds three packed signed
// Q2.18 coefficients (coefficient k in bits 21k+20..21k); other indexes are ignored.
// The user must write rows only while no transaction is in flight; the block does not
// enforce this. cfg_ready is always high. The datapath is one pipeline that takes a new
// transaction every cycle while the receiver takes results: line products, line sum,
// distance and normal products, sums, distance squared, range check, a 32 stage divider
// with one quotient bit per stage and the output register. The multipliers use one
// 32x32 partial product per stage, which sets the product stage counts.
// Reset clears the valid bits and loads all matrix rows with zero. When the receiver
// holds out_tready low with a result waiting, the whole pipeline freezes, in_tready
// drops, and nothing is dropped or repeated.
// Depends on emld_pkg, emld_mul, emld_dly and emld_div.
module epipolar_max_line_distance (
  input  logic                                clk,
  input  logic                                rst_n,
  // x1, y1, x2, y2
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [emld_pkg::IN_W-1:0]           in_tdata,
  // error
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [emld_pkg::ERR_W-1:0]          out_tdata,
  // degenerate
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [emld_pkg::CFG_A_W-1:0]        cfg_addr,
  input  logic [emld_pkg::ROW_W-1:0]          cfg_data
);

  localparam int PT_W  = emld_pkg::PT_W;
  localparam int L_W   = emld_pkg::L_W;
  localparam int D_W   = emld_pkg::D_W;
  localparam int N_W   = emld_pkg::N_W;
  localparam int D2_W  = emld_pkg::D2_W;
  localparam int M_W   = emld_pkg::M_W;
  localparam int ERR_W = emld_pkg::ERR_W;
  localparam int ST_A  = emld_pkg::mul_stages(emld_pkg::COEF_W, PT_W);
  localparam int ST_B  = emld_pkg::mul_stages(L_W, L_W);
  localparam int ST_C  = emld_pkg::mul_stages(D_W, D_W);
  localparam int LAT   = (ST_A + 2) + 1 + (ST_B + 2) + 1 + (ST_C + 2) + 1 + ERR_W + 1;
  localparam int FL_W  = $bits(emld_pkg::side_flags_t);

  logic                            en;
  logic [LAT-1:0]                  vld_r;
  logic [emld_pkg::ROW_W-1:0]      row_r [0:2];
  logic [emld_pkg::IN_W-1:0]       pts_d;
  logic signed [L_W-1:0]           l_r   [0:1][0:2];
  logic signed [D_W-1:0]           d_r   [0:1];
  logic [N_W-1:0]                  n_r   [0:1];
  logic [D2_W-1:0]                 rem_r [0:1];
  logic [M_W-1:0]                  m_r   [0:1];
  emld_pkg::side_flags_t           fl_r  [0:1];
  emld_pkg::side_flags_t           fl_d  [0:1];
  logic [ERR_W-1:0]                q_d   [0:1];
  logic [ERR_W-1:0]                e0, e1;
  logic                            deg_any;
  logic [ERR_W-1:0]                error_r;
  logic                            deg_r;

  // pipeline advances unless a result is held
  assign en        = ~vld_r[LAT-1] | out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // matrix rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= '0;
      row_r[1] <= '0;
      row_r[2] <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        emld_pkg::REG_ROW0: row_r[0] <= cfg_data;
        emld_pkg::REG_ROW1: row_r[1] <= cfg_data;
        emld_pkg::REG_ROW2: row_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // points wait for the line coefficients
  emld_dly #(.W(emld_pkg::IN_W), .N(ST_A + 3)) u_pts_dly (
    .clk(clk), .en(en), .d(in_tdata), .q(pts_d)
  );

  // side 0: line F*p1 against p2; side 1: line F^T*p2 against p1
  for (genvar s = 0; s < 2; s++) begin : g_side
    logic signed [PT_W-1:0] px, py, qx, qy;

    if (s == 0) begin : g_fwd
      assign px = $signed(in_tdata[PT_W-1:0]);
      assign py = $signed(in_tdata[2*PT_W-1:PT_W]);
      assign qx = $signed(pts_d[3*PT_W-1:2*PT_W]);
      assign qy = $signed(pts_d[4*PT_W-1:3*PT_W]);
    end else begin : g_trn
      assign px = $signed(in_tdata[3*PT_W-1:2*PT_W]);
      assign py = $signed(in_tdata[4*PT_W-1:3*PT_W]);
      assign qx = $signed(pts_d[PT_W-1:0]);
      assign qy = $signed(pts_d[2*PT_W-1:PT_W]);
    end

    // line coefficients
    for (genvar r = 0; r < 3; r++) begin : g_line
      logic signed [emld_pkg::COEF_W-1:0] c0, c1, c2;
      logic signed [emld_pkg::PA_W-1:0]   p0, p1;

      if (s == 0) begin : g_rows
        assign c0 = emld_pkg::coef(row_r[r], 0);
        assign c1 = emld_pkg::coef(row_r[r], 1);
        assign c2 = emld_pkg::coef(row_r[r], 2);
      end else begin : g_cols
        assign c0 = emld_pkg::coef(row_r[0], r);
        assign c1 = emld_pkg::coef(row_r[1], r);
        assign c2 = emld_pkg::coef(row_r[2], r);
      end

      emld_mul #(.WA(emld_pkg::COEF_W), .WB(PT_W), .STAGES(ST_A)) u_mx (
        .clk(clk), .en(en), .a(c0), .b(px), .p(p0)
      );
      emld_mul #(.WA(emld_pkg::COEF_W), .WB(PT_W), .STAGES(ST_A)) u_my (
        .clk(clk), .en(en), .a(c1), .b(py), .p(p1)
      );

      always_ff @(posedge clk) begin
        if (en) begin
          l_r[s][r] <= {{(L_W-emld_pkg::PA_W){p0[emld_pkg::PA_W-1]}}, p0}
                     + {{(L_W-emld_pkg::PA_W){p1[emld_pkg::PA_W-1]}}, p1}
                     + ({{(L_W-emld_pkg::COEF_W){c2[emld_pkg::COEF_W-1]}}, c2} << 16);
        end
      end
    end

    // distance and normal products
    logic signed [emld_pkg::PD_W-1:0] md0, md1;
    logic signed [emld_pkg::PN_W-1:0] mn0, mn1;
    logic [L_W-1:0]                   l2_d;
    logic signed [D2_W-1:0]           d2;
    logic [N_W-1:0]                   n_d;
    logic [D2_W-1:0]                  d2u;

    emld_mul #(.WA(L_W), .WB(PT_W), .STAGES(ST_B)) u_md0 (
      .clk(clk), .en(en), .a(l_r[s][0]), .b(qx), .p(md0)
    );
    emld_mul #(.WA(L_W), .WB(PT_W), .STAGES(ST_B)) u_md1 (
      .clk(clk), .en(en), .a(l_r[s][1]), .b(qy), .p(md1)
    );
    emld_mul #(.WA(L_W), .WB(L_W), .STAGES(ST_B)) u_mn0 (
      .clk(clk), .en(en), .a(l_r[s][0]), .b(l_r[s][0]), .p(mn0)
    );
    emld_mul #(.WA(L_W), .WB(L_W), .STAGES(ST_B)) u_mn1 (
      .clk(clk), .en(en), .a(l_r[s][1]), .b(l_r[s][1]), .p(mn1)
    );
    emld_dly #(.W(L_W), .N(ST_B + 2)) u_l2_dly (
      .clk(clk), .en(en), .d(l_r[s][2]), .q(l2_d)
    );

    // distance value and normal length
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s] <= {{(D_W-emld_pkg::PD_W){md0[emld_pkg::PD_W-1]}}, md0}
                + {{(D_W-emld_pkg::PD_W){md1[emld_pkg::PD_W-1]}}, md1}
                + ({{(D_W-L_W){l2_d[L_W-1]}}, l2_d} << 16);
        n_r[s] <= N_W'(mn0[emld_pkg::PN_W-2:0]) + N_W'(mn1[emld_pkg::PN_W-2:0]);
      end
    end

    // distance squared
    emld_mul #(.WA(D_W), .WB(D_W), .STAGES(ST_C)) u_d2 (
      .clk(clk), .en(en), .a(d_r[s]), .b(d_r[s]), .p(d2)
    );
    emld_dly #(.W(N_W), .N(ST_C + 2)) u_n_dly (
      .clk(clk), .en(en), .d(n_r[s]), .q(n_d)
    );

    assign d2u = $unsigned(d2);

    // range check and divider setup
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]    <= d2u;
        m_r[s]      <= M_W'(n_d) << 16;
        fl_r[s].deg <= (n_d == '0);
        fl_r[s].sat <= (d2u >= (D2_W'(n_d) << 48));
      end
    end

    emld_div #(.RW(D2_W), .MW(M_W), .QW(ERR_W)) u_div (
      .clk(clk), .en(en), .rem_in(rem_r[s]), .m_in(m_r[s]), .q(q_d[s])
    );
    emld_dly #(.W(FL_W), .N(ERR_W)) u_fl_dly (
      .clk(clk), .en(en), .d(fl_r[s]), .q(fl_d[s])
    );
  end

  // larger of the two sides, all ones when either side is degenerate
  assign e0      = fl_d[0].sat ? '1 : q_d[0];
  assign e1      = fl_d[1].sat ? '1 : q_d[1];
  assign deg_any = fl_d[0].deg | fl_d[1].deg;

  always_ff @(posedge clk) begin
    if (en) begin
      error_r <= deg_any ? '1 : ((e0 > e1) ? e0 : e1);
      deg_r   <= deg_any;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = error_r;
  assign out_tuser  = deg_r;

  // a degenerate line always reports the largest error
  a_deg_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '1)
    else $error("degenerate result without maximum error");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a held result freezes every valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule
